// ----- rtl/clock_offset_skew_kalman_defines.svh -----
// ----------------------------------------------------------------------------
// Clock offset / skew estimator: assertion macros
// Shared property shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef CLOCK_OFFSET_SKEW_KALMAN_DEFINES_SVH
`define CLOCK_OFFSET_SKEW_KALMAN_DEFINES_SVH

// same-cycle implication, idle during reset
`define COSK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, idle during reset
`define COSK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ----- rtl/cosk_pkg.sv -----
// ----------------------------------------------------------------------------
// Clock offset / skew estimator: shared package
// Word types, codes, microcode ROM and helpers.
// ----------------------------------------------------------------------------
package cosk_pkg;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [1:0] {
    OP_UPDATE = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT    = 3'd0,
    ST_UPDATED = 3'd1,
    ST_SOON    = 3'd2,
    ST_OUTLIER = 3'd3,
    ST_STAMP   = 3'd4,
    ST_CLEARED = 3'd5
  } st_t;

  typedef enum logic [2:0] {
    CFG_INTERVAL   = 3'd0,
    CFG_SIG_MEAS   = 3'd1,
    CFG_START_OFF  = 3'd2,
    CFG_START_SKEW = 3'd3,
    CFG_DRIFT_OFF  = 3'd4,
    CFG_DRIFT_SKEW = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [63:0] device_time;
    logic signed [63:0] local_time;
  } in_word_t;

  typedef struct packed {
    st_t                status;
    logic signed [63:0] mapped_time;
    logic signed [63:0] offset_estimate;
    logic signed [63:0] skew_estimate;
  } out_word_t;

  // operand / destination selects of the datapath
  typedef enum logic [4:0] {
    R_ZERO, R_DEV, R_LOC, R_OFF, R_SKEW, R_COO, R_COS, R_CSS, R_LAST, R_DT,
    R_XP, R_RES, R_T, R_P00, R_P01, R_P11, R_S, R_K0, R_K1, R_TMP, R_MAP,
    C_SSO, C_SSS, C_SSS24, C_SDO, C_SDS, C_SDS24, C_SM, C_IV16, C_SM17
  } sel_t;

  typedef enum logic [3:0] {
    U_ADD, U_SUB, U_SATT, U_LT, U_GT, U_MUL, U_DIV, U_ENDQ, U_END
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    sel_t       dst;
    sel_t       a;
    sel_t       b;
    logic [6:0] sh;
    st_t        stat;
  } uop_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic push;
    st_t  status;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic flag;
    logic unit_done;
    logic can_push;
  } sts_t;

  localparam logic [5:0] PC_INIT  = 6'd0;
  localparam logic [5:0] PC_FILT  = 6'd8;
  localparam logic [5:0] PC_QUERY = 6'd46;

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic uop_t mk(input kind_t k, input sel_t d, input sel_t a,
                              input sel_t b, input logic [6:0] sh, input st_t st);
    uop_t u;
    u.kind = k;
    u.dst  = d;
    u.a    = a;
    u.b    = b;
    u.sh   = sh;
    u.stat = st;
    return u;
  endfunction

  function automatic uop_t ucode(input logic [5:0] pc);
    uop_t u;
    case (pc)
      // start from a pair
      6'd0:  u = mk(U_SUB, R_OFF, R_LOC, R_DEV, 7'd0, ST_INIT);
      6'd1:  u = mk(U_SATT, R_OFF, R_OFF, R_ZERO, 7'd0, ST_INIT);
      6'd2:  u = mk(U_SUB, R_SKEW, R_ZERO, R_ZERO, 7'd0, ST_INIT);
      6'd3:  u = mk(U_MUL, R_COO, C_SSO, C_SSO, 7'd0, ST_INIT);
      6'd4:  u = mk(U_SUB, R_COS, R_ZERO, R_ZERO, 7'd0, ST_INIT);
      6'd5:  u = mk(U_MUL, R_CSS, C_SSS, C_SSS24, 7'd0, ST_INIT);
      6'd6:  u = mk(U_ADD, R_LAST, R_DEV, R_ZERO, 7'd0, ST_INIT);
      6'd7:  u = mk(U_ENDQ, R_ZERO, R_ZERO, R_ZERO, 7'd0, ST_INIT);
      // filter step
      6'd8:  u = mk(U_SUB, R_DT, R_DEV, R_LAST, 7'd0, ST_UPDATED);
      6'd9:  u = mk(U_LT, R_ZERO, R_DT, C_IV16, 7'd0, ST_SOON);
      6'd10: u = mk(U_MUL, R_T, R_DT, R_SKEW, 7'd62, ST_UPDATED);
      6'd11: u = mk(U_ADD, R_XP, R_OFF, R_T, 7'd0, ST_UPDATED);
      6'd12: u = mk(U_SUB, R_RES, R_LOC, R_DEV, 7'd0, ST_UPDATED);
      6'd13: u = mk(U_SUB, R_RES, R_RES, R_XP, 7'd0, ST_UPDATED);
      6'd14: u = mk(U_GT, R_ZERO, R_RES, C_SM17, 7'd0, ST_OUTLIER);
      6'd15: u = mk(U_MUL, R_T, R_DT, R_COS, 7'd48, ST_UPDATED);
      6'd16: u = mk(U_ADD, R_P00, R_COO, R_T, 7'd0, ST_UPDATED);
      6'd17: u = mk(U_ADD, R_P00, R_P00, R_T, 7'd0, ST_UPDATED);
      6'd18: u = mk(U_MUL, R_TMP, R_DT, R_DT, 7'd32, ST_UPDATED);
      6'd19: u = mk(U_MUL, R_TMP, R_TMP, R_CSS, 7'd56, ST_UPDATED);
      6'd20: u = mk(U_ADD, R_P00, R_P00, R_TMP, 7'd0, ST_UPDATED);
      6'd21: u = mk(U_MUL, R_TMP, C_SDO, C_SDO, 7'd0, ST_UPDATED);
      6'd22: u = mk(U_MUL, R_TMP, R_DT, R_TMP, 7'd32, ST_UPDATED);
      6'd23: u = mk(U_ADD, R_P00, R_P00, R_TMP, 7'd0, ST_UPDATED);
      6'd24: u = mk(U_MUL, R_TMP, R_DT, R_CSS, 7'd40, ST_UPDATED);
      6'd25: u = mk(U_ADD, R_P01, R_COS, R_TMP, 7'd0, ST_UPDATED);
      6'd26: u = mk(U_MUL, R_TMP, C_SDS, C_SDS24, 7'd0, ST_UPDATED);
      6'd27: u = mk(U_MUL, R_TMP, R_DT, R_TMP, 7'd32, ST_UPDATED);
      6'd28: u = mk(U_ADD, R_P11, R_CSS, R_TMP, 7'd0, ST_UPDATED);
      6'd29: u = mk(U_MUL, R_TMP, C_SM, C_SM, 7'd0, ST_UPDATED);
      6'd30: u = mk(U_ADD, R_S, R_P00, R_TMP, 7'd0, ST_UPDATED);
      6'd31: u = mk(U_DIV, R_K0, R_P00, R_S, 7'd62, ST_UPDATED);
      6'd32: u = mk(U_DIV, R_K1, R_P01, R_S, 7'd32, ST_UPDATED);
      6'd33: u = mk(U_MUL, R_TMP, R_K0, R_RES, 7'd62, ST_UPDATED);
      6'd34: u = mk(U_ADD, R_TMP, R_XP, R_TMP, 7'd0, ST_UPDATED);
      6'd35: u = mk(U_SATT, R_OFF, R_TMP, R_ZERO, 7'd0, ST_UPDATED);
      6'd36: u = mk(U_MUL, R_TMP, R_K1, R_RES, 7'd18, ST_UPDATED);
      6'd37: u = mk(U_ADD, R_SKEW, R_SKEW, R_TMP, 7'd0, ST_UPDATED);
      6'd38: u = mk(U_MUL, R_TMP, R_K0, R_P00, 7'd62, ST_UPDATED);
      6'd39: u = mk(U_SUB, R_COO, R_P00, R_TMP, 7'd0, ST_UPDATED);
      6'd40: u = mk(U_MUL, R_TMP, R_K0, R_P01, 7'd62, ST_UPDATED);
      6'd41: u = mk(U_SUB, R_COS, R_P01, R_TMP, 7'd0, ST_UPDATED);
      6'd42: u = mk(U_MUL, R_TMP, R_K1, R_P01, 7'd40, ST_UPDATED);
      6'd43: u = mk(U_SUB, R_CSS, R_P11, R_TMP, 7'd0, ST_UPDATED);
      6'd44: u = mk(U_ADD, R_LAST, R_DEV, R_ZERO, 7'd0, ST_UPDATED);
      6'd45: u = mk(U_END, R_ZERO, R_ZERO, R_ZERO, 7'd0, ST_UPDATED);
      // timestamp query
      6'd46: u = mk(U_SUB, R_DT, R_DEV, R_LAST, 7'd0, ST_STAMP);
      6'd47: u = mk(U_MUL, R_TMP, R_DT, R_SKEW, 7'd62, ST_STAMP);
      6'd48: u = mk(U_ADD, R_MAP, R_DEV, R_OFF, 7'd0, ST_STAMP);
      6'd49: u = mk(U_ADD, R_MAP, R_MAP, R_TMP, 7'd0, ST_STAMP);
      6'd50: u = mk(U_SATT, R_MAP, R_MAP, R_ZERO, 7'd0, ST_STAMP);
      default: u = mk(U_END, R_ZERO, R_ZERO, R_ZERO, 7'd0, ST_STAMP);
    endcase
    return u;
  endfunction

endpackage

// ----- rtl/cosk_mul.sv -----
// ----------------------------------------------------------------------------
// Clock offset / skew estimator: multiplier
// Signed 64x64 product from four 32x32 partials, floor shift, saturate.
// ----------------------------------------------------------------------------
module cosk_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  input  logic [6:0]         sh,
  output logic               done,
  output logic signed [63:0] res
);

  localparam logic [2:0] NegStep = 3'd4;
  localparam logic [2:0] SatStep = 3'd5;

  logic         busy;
  logic [2:0]   cnt;
  logic [63:0]  ma, mb;
  logic         neg;
  logic [6:0]   shr;
  logic [127:0] acc;

  logic [31:0]  a_part, b_part;
  logic [63:0]  pp;
  logic [1:0]   sum_ij;
  logic [127:0] pp_sh;
  logic signed [127:0] shifted;
  logic signed [63:0]  sat_val;

  assign a_part = cnt[1] ? ma[63:32] : ma[31:0];
  assign b_part = cnt[0] ? mb[63:32] : mb[31:0];
  assign pp     = a_part * b_part;
  assign sum_ij = {1'b0, cnt[1]} + {1'b0, cnt[0]};
  assign pp_sh  = {64'd0, pp} << {sum_ij, 5'd0};

  always_comb begin
    shifted = $signed(acc) >>> shr;
    if (shifted[127:64] == {64{shifted[63]}}) begin
      sat_val = shifted[63:0];
    end else begin
      sat_val = shifted[127] ? cosk_pkg::S64_MIN : cosk_pkg::S64_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
        ma   <= cosk_pkg::mag(a);
        mb   <= cosk_pkg::mag(b);
        neg  <= a[63] ^ b[63];
        shr  <= sh;
        acc  <= '0;
      end else if (busy) begin
        case (cnt)
          NegStep: begin
            if (neg) acc <= -acc;
            cnt <= cnt + 3'd1;
          end
          SatStep: begin
            res  <= sat_val;
            done <= 1'b1;
            busy <= 1'b0;
          end
          default: begin
            acc <= acc + pp_sh;
            cnt <= cnt + 3'd1;
          end
        endcase
      end
    end
  end

endmodule

// ----- rtl/cosk_div.sv -----
// ----------------------------------------------------------------------------
// Clock offset / skew estimator: divider
// Restoring divide of (|num| << sh) by a positive den, one bit a cycle.
// ----------------------------------------------------------------------------
module cosk_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  input  logic [6:0]         sh,
  output logic               done,
  output logic signed [63:0] res
);

  localparam logic [6:0] LastBit = 7'd127;

  logic         busy, fin, neg;
  logic [6:0]   cnt;
  logic [127:0] nsh, q;
  logic [63:0]  d, r;
  logic [64:0]  rr;
  logic         ge;
  logic         ovf;

  assign rr  = {r, nsh[127]};
  assign ge  = rr >= {1'b0, d};
  assign ovf = |q[127:63];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= 7'd0;
    end else begin
      done <= 1'b0;
      fin  <= 1'b0;
      if (start) begin
        if (den > 64'sd0) begin
          busy <= 1'b1;
          nsh  <= {64'd0, cosk_pkg::mag(num)} << sh;
          d    <= den;
          r    <= '0;
          q    <= '0;
          cnt  <= 7'd0;
          neg  <= num[63];
        end else begin
          // nonpositive divisor gives zero gain
          res  <= '0;
          done <= 1'b1;
        end
      end else if (busy) begin
        r   <= ge ? 64'(rr - {1'b0, d}) : rr[63:0];
        q   <= {q[126:0], ge};
        nsh <= nsh << 1;
        cnt <= cnt + 7'd1;
        if (cnt == LastBit) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end else if (fin) begin
        done <= 1'b1;
        if (ovf) begin
          res <= neg ? cosk_pkg::S64_MIN : cosk_pkg::S64_MAX;
        end else begin
          res <= neg ? -$signed(q[63:0]) : $signed(q[63:0]);
        end
      end
    end
  end

endmodule

// ----- rtl/cosk_dpath.sv -----
// ----------------------------------------------------------------------------
// Clock offset / skew estimator: datapath
// Filter state, config registers, ALU, mul/div units and result register.
// ----------------------------------------------------------------------------
module cosk_dpath #(
  parameter int TIME_BITS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  cosk_pkg::cmd_t      cmd,
  output cosk_pkg::sts_t      sts,
  input  cosk_pkg::in_word_t  item,
  input  logic                cfg_valid,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output logic                result_valid,
  input  logic                result_stall,
  output cosk_pkg::out_word_t result
);

  localparam int PadBits = 64 - TIME_BITS;
  localparam logic signed [63:0] TMax = $signed(64'h7FFF_FFFF_FFFF_FFFF >> PadBits);
  localparam logic signed [63:0] TMin = ~TMax;

  function automatic logic signed [63:0] narrow(input logic signed [63:0] x);
    return (x <<< PadBits) >>> PadBits;
  endfunction

  function automatic logic signed [63:0] satt(input logic signed [63:0] x);
    return (x > TMax) ? TMax : ((x < TMin) ? TMin : x);
  endfunction

  function automatic logic signed [63:0] sat65(input logic [64:0] s);
    if (s[64] != s[63]) return s[64] ? cosk_pkg::S64_MIN : cosk_pkg::S64_MAX;
    return $signed(s[63:0]);
  endfunction

  logic [31:0] iv, sm, sso, sss, sdo, sds;
  logic signed [63:0] dev, loc, off, skew, coo, cos, css, last, dt, xp, res;
  logic signed [63:0] t, p00, p01, p11, s, k0, k1, tmp, map;

  logic signed [63:0] a_val, b_val, alu, wdata;
  logic [64:0]        add65, sub65;
  logic               we;
  cosk_pkg::sel_t     wsel, dst_q;
  cosk_pkg::uop_t     u;
  logic               mul_start, div_start, mul_done, div_done;
  logic signed [63:0] mul_res, div_res;

  assign u = cmd.uop;

  always_comb begin
    case (u.a)
      cosk_pkg::R_DEV:   a_val = dev;
      cosk_pkg::R_LOC:   a_val = loc;
      cosk_pkg::R_OFF:   a_val = off;
      cosk_pkg::R_SKEW:  a_val = skew;
      cosk_pkg::R_COO:   a_val = coo;
      cosk_pkg::R_COS:   a_val = cos;
      cosk_pkg::R_CSS:   a_val = css;
      cosk_pkg::R_LAST:  a_val = last;
      cosk_pkg::R_DT:    a_val = dt;
      cosk_pkg::R_XP:    a_val = xp;
      cosk_pkg::R_RES:   a_val = res;
      cosk_pkg::R_T:     a_val = t;
      cosk_pkg::R_P00:   a_val = p00;
      cosk_pkg::R_P01:   a_val = p01;
      cosk_pkg::R_P11:   a_val = p11;
      cosk_pkg::R_S:     a_val = s;
      cosk_pkg::R_K0:    a_val = k0;
      cosk_pkg::R_K1:    a_val = k1;
      cosk_pkg::R_TMP:   a_val = tmp;
      cosk_pkg::R_MAP:   a_val = map;
      cosk_pkg::C_SSO:   a_val = {32'd0, sso};
      cosk_pkg::C_SSS:   a_val = {32'd0, sss};
      cosk_pkg::C_SSS24: a_val = {8'd0, sss, 24'd0};
      cosk_pkg::C_SDO:   a_val = {32'd0, sdo};
      cosk_pkg::C_SDS:   a_val = {32'd0, sds};
      cosk_pkg::C_SDS24: a_val = {8'd0, sds, 24'd0};
      cosk_pkg::C_SM:    a_val = {32'd0, sm};
      cosk_pkg::C_IV16:  a_val = {16'd0, iv, 16'd0};
      cosk_pkg::C_SM17:  a_val = {15'd0, sm, 17'd0};
      default:           a_val = '0;
    endcase
  end

  always_comb begin
    case (u.b)
      cosk_pkg::R_DEV:   b_val = dev;
      cosk_pkg::R_LOC:   b_val = loc;
      cosk_pkg::R_OFF:   b_val = off;
      cosk_pkg::R_SKEW:  b_val = skew;
      cosk_pkg::R_COO:   b_val = coo;
      cosk_pkg::R_COS:   b_val = cos;
      cosk_pkg::R_CSS:   b_val = css;
      cosk_pkg::R_LAST:  b_val = last;
      cosk_pkg::R_DT:    b_val = dt;
      cosk_pkg::R_XP:    b_val = xp;
      cosk_pkg::R_RES:   b_val = res;
      cosk_pkg::R_T:     b_val = t;
      cosk_pkg::R_P00:   b_val = p00;
      cosk_pkg::R_P01:   b_val = p01;
      cosk_pkg::R_P11:   b_val = p11;
      cosk_pkg::R_S:     b_val = s;
      cosk_pkg::R_K0:    b_val = k0;
      cosk_pkg::R_K1:    b_val = k1;
      cosk_pkg::R_TMP:   b_val = tmp;
      cosk_pkg::R_MAP:   b_val = map;
      cosk_pkg::C_SSO:   b_val = {32'd0, sso};
      cosk_pkg::C_SSS:   b_val = {32'd0, sss};
      cosk_pkg::C_SSS24: b_val = {8'd0, sss, 24'd0};
      cosk_pkg::C_SDO:   b_val = {32'd0, sdo};
      cosk_pkg::C_SDS:   b_val = {32'd0, sds};
      cosk_pkg::C_SDS24: b_val = {8'd0, sds, 24'd0};
      cosk_pkg::C_SM:    b_val = {32'd0, sm};
      cosk_pkg::C_IV16:  b_val = {16'd0, iv, 16'd0};
      cosk_pkg::C_SM17:  b_val = {15'd0, sm, 17'd0};
      default:           b_val = '0;
    endcase
  end

  assign add65 = {a_val[63], a_val} + {b_val[63], b_val};
  assign sub65 = {a_val[63], a_val} - {b_val[63], b_val};

  always_comb begin
    case (u.kind)
      cosk_pkg::U_ADD: alu = sat65(add65);
      cosk_pkg::U_SUB: alu = sat65(sub65);
      default:         alu = satt(a_val);
    endcase
  end

  assign sts.flag      = (u.kind == cosk_pkg::U_LT) ? (a_val < b_val) : (a_val > b_val);
  assign sts.unit_done = mul_done | div_done;
  assign sts.can_push  = !result_valid || !result_stall;

  assign mul_start = cmd.exec && (u.kind == cosk_pkg::U_MUL);
  assign div_start = cmd.exec && (u.kind == cosk_pkg::U_DIV);

  cosk_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (a_val),
    .b     (b_val),
    .sh    (u.sh),
    .done  (mul_done),
    .res   (mul_res)
  );

  cosk_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (a_val),
    .den   (b_val),
    .sh    (u.sh),
    .done  (div_done),
    .res   (div_res)
  );

  always_comb begin
    we    = 1'b0;
    wsel  = u.dst;
    wdata = alu;
    if (mul_done || div_done) begin
      we    = 1'b1;
      wsel  = dst_q;
      wdata = mul_done ? mul_res : div_res;
    end else if (cmd.exec && (u.kind == cosk_pkg::U_ADD || u.kind == cosk_pkg::U_SUB ||
                              u.kind == cosk_pkg::U_SATT)) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_start || div_start) dst_q <= u.dst;
    if (cmd.load) begin
      dev <= narrow(item.device_time);
      loc <= narrow(item.local_time);
      map <= '0;
    end else if (we) begin
      case (wsel)
        cosk_pkg::R_OFF:  off  <= wdata;
        cosk_pkg::R_SKEW: skew <= wdata;
        cosk_pkg::R_COO:  coo  <= wdata;
        cosk_pkg::R_COS:  cos  <= wdata;
        cosk_pkg::R_CSS:  css  <= wdata;
        cosk_pkg::R_LAST: last <= wdata;
        cosk_pkg::R_DT:   dt   <= wdata;
        cosk_pkg::R_XP:   xp   <= wdata;
        cosk_pkg::R_RES:  res  <= wdata;
        cosk_pkg::R_T:    t    <= wdata;
        cosk_pkg::R_P00:  p00  <= wdata;
        cosk_pkg::R_P01:  p01  <= wdata;
        cosk_pkg::R_P11:  p11  <= wdata;
        cosk_pkg::R_S:    s    <= wdata;
        cosk_pkg::R_K0:   k0   <= wdata;
        cosk_pkg::R_K1:   k1   <= wdata;
        cosk_pkg::R_TMP:  tmp  <= wdata;
        cosk_pkg::R_MAP:  map  <= wdata;
        default: ;
      endcase
    end
    if (rst) begin
      off  <= '0;
      skew <= '0;
      coo  <= '0;
      cos  <= '0;
      css  <= '0;
      last <= '0;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      iv  <= '0;
      sm  <= '0;
      sso <= '0;
      sss <= '0;
      sdo <= '0;
      sds <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        cosk_pkg::CFG_INTERVAL:   iv  <= cfg_data;
        cosk_pkg::CFG_SIG_MEAS:   sm  <= cfg_data;
        cosk_pkg::CFG_START_OFF:  sso <= cfg_data;
        cosk_pkg::CFG_START_SKEW: sss <= cfg_data;
        cosk_pkg::CFG_DRIFT_OFF:  sdo <= cfg_data;
        cosk_pkg::CFG_DRIFT_SKEW: sds <= cfg_data;
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.push) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (cmd.push) begin
      result.status          <= cmd.status;
      result.mapped_time     <= map;
      result.offset_estimate <= off;
      result.skew_estimate   <= skew;
    end
  end

endmodule

// ----- rtl/cosk_ctrl.sv -----
// ----------------------------------------------------------------------------
// Clock offset / skew estimator: controller
// Microcode sequencer: picks the program for each word and steps it.
// ----------------------------------------------------------------------------
module cosk_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  input  logic [1:0]     item_op,
  output logic           item_stall,
  output cosk_pkg::cmd_t cmd,
  input  cosk_pkg::sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_WAIT = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t         state, state_next;
  logic [5:0]     pc, pc_next;
  logic [1:0]     op_q, op_q_next;
  logic           ready_flag, ready_flag_next;
  cosk_pkg::st_t  st_q, st_q_next;
  cosk_pkg::uop_t uop;

  assign uop        = cosk_pkg::ucode(pc);
  assign item_stall = (state != S_IDLE);

  always_comb begin
    state_next      = state;
    pc_next         = pc;
    op_q_next       = op_q;
    ready_flag_next = ready_flag;
    st_q_next       = st_q;
    cmd.load        = 1'b0;
    cmd.exec        = 1'b0;
    cmd.push        = 1'b0;
    cmd.status      = st_q;
    cmd.uop         = uop;
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          cmd.load  = 1'b1;
          op_q_next = item_op;
          if (item_op != cosk_pkg::OP_UPDATE && item_op != cosk_pkg::OP_QUERY) begin
            ready_flag_next = 1'b0;
            st_q_next       = cosk_pkg::ST_CLEARED;
            state_next      = S_DONE;
          end else begin
            state_next = S_RUN;
            if (!ready_flag) pc_next = cosk_pkg::PC_INIT;
            else if (item_op == cosk_pkg::OP_QUERY) pc_next = cosk_pkg::PC_QUERY;
            else pc_next = cosk_pkg::PC_FILT;
          end
        end
      end
      S_RUN: begin
        unique case (uop.kind)
          cosk_pkg::U_LT, cosk_pkg::U_GT: begin
            cmd.exec = 1'b1;
            if (sts.flag) begin
              st_q_next  = uop.stat;
              state_next = S_DONE;
            end else begin
              pc_next = pc + 6'd1;
            end
          end
          cosk_pkg::U_MUL, cosk_pkg::U_DIV: begin
            cmd.exec   = 1'b1;
            state_next = S_WAIT;
          end
          cosk_pkg::U_ENDQ: begin
            ready_flag_next = 1'b1;
            if (op_q == cosk_pkg::OP_QUERY) begin
              pc_next = cosk_pkg::PC_QUERY;
            end else begin
              st_q_next  = uop.stat;
              state_next = S_DONE;
            end
          end
          cosk_pkg::U_END: begin
            st_q_next  = uop.stat;
            state_next = S_DONE;
          end
          default: begin
            cmd.exec = 1'b1;
            pc_next  = pc + 6'd1;
          end
        endcase
      end
      S_WAIT: begin
        if (sts.unit_done) begin
          pc_next    = pc + 6'd1;
          state_next = S_RUN;
        end
      end
      S_DONE: begin
        if (sts.can_push) begin
          cmd.push   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pc         <= cosk_pkg::PC_INIT;
      op_q       <= cosk_pkg::OP_UPDATE;
      ready_flag <= 1'b0;
      st_q       <= cosk_pkg::ST_INIT;
    end else begin
      state      <= state_next;
      pc         <= pc_next;
      op_q       <= op_q_next;
      ready_flag <= ready_flag_next;
      st_q       <= st_q_next;
    end
  end

endmodule

// ----- rtl/clock_offset_skew_kalman.sv -----
// ----------------------------------------------------------------------------
// Clock offset / skew Kalman estimator: top level
// An update runs 15 multiplies and two bit-serial divides.
// Reset: estimates, covariances and config registers go to zero, filter uninitialized.
// ----------------------------------------------------------------------------
module clock_offset_skew_kalman #(
  parameter int TIME_BITS = 64
) (
  input  logic                clk,
  input  logic                rst,
  // input words
  input  logic                item_valid,
  output logic                item_stall,
  input  cosk_pkg::in_word_t  item,
  // result words
  output logic                result_valid,
  input  logic                result_stall,
  output cosk_pkg::out_word_t result,
  // configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  // Controller and datapath talk only over this command / status pair.
  cosk_pkg::cmd_t cmd;
  cosk_pkg::sts_t sts;

  // Config writes land directly in the config registers, so the port never pushes back.
  assign cfg_ready = 1'b1;

  // Sequencer: takes one word at a time and holds item_stall until the
  // word's result has moved into the result register.
  cosk_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_op    (item.op),
    .item_stall (item_stall),
    .cmd        (cmd),
    .sts        (sts)
  );

  // Datapath: state, config, shared multiplier and divider, result register.
  // The result register frees the sequencer to take the next word while
  // the downstream side still stalls.
  cosk_dpath #(
    .TIME_BITS (TIME_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .item         (item),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

// ----- rtl/cosk_checker.sv -----
// ----------------------------------------------------------------------------
// Clock offset / skew estimator: port checker
// Watches the top-level ports over time.
// ----------------------------------------------------------------------------
`include "clock_offset_skew_kalman_defines.svh"

module cosk_checker (
  input logic                clk,
  input logic                rst,
  input logic                item_valid,
  input logic                item_stall,
  input logic                result_valid,
  input logic                result_stall,
  input cosk_pkg::out_word_t result
);

  // one word in flight: an accepted word stalls the next one
  `COSK_ASSERT_NEXT(a_one_in_flight, item_valid && !item_stall, item_stall)
  `COSK_ASSERT_NEXT(a_result_held, result_valid && result_stall, result_valid)
  `COSK_ASSERT_NEXT(a_result_stable, result_valid && result_stall, $stable(result))
  // only a timestamp answer carries a mapped time
  `COSK_ASSERT_NOW(a_map_only_query, result_valid, result.status == cosk_pkg::ST_STAMP || result.mapped_time == 64'sd0)

endmodule

bind clock_offset_skew_kalman cosk_checker u_chk (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

// ----- test/clock_offset_skew_kalman_tb.sv -----
// ----------------------------------------------------------------------------
// Clock offset / skew Kalman estimator: testbench
// Drives update, query and clear words through the valid/stall channels,
// predicts every result with a fixed-point model of the filter and compares
// each result word field by field. Register settings change between phases.
// ----------------------------------------------------------------------------
module clock_offset_skew_kalman_tb;
  import cosk_pkg::*;

  // opcode three has no package name; the block treats it as a clear
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam longint ONE_SEC = 64'sh1_0000_0000;
  localparam int N_PHASES = 5;
  localparam int ITEMS_PER_PHASE = 276;

  // --------------------------------------------------------------------------
  // Filter predictor and store of expected result words
  // --------------------------------------------------------------------------
  class kalman_scoreboard;
    logic [31:0] regs [6];
    bit          primed;
    longint      off_est, skew_est, p_oo, p_os, p_ss, last_upd;
    out_word_t   expected_words [$];
    int          mismatches;
    int          checked;
    int          status_seen [6];

    function new();
      foreach (regs[i]) regs[i] = '0;
      primed = 0;
      off_est = 0; skew_est = 0; p_oo = 0; p_os = 0; p_ss = 0; last_upd = 0;
      mismatches = 0;
      checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [31:0] data);
      regs[idx] = data;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // saturating add / subtract
    function longint add_sat(longint a, longint b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
      return s[63:0];
    endfunction

    function longint sub_sat(longint a, longint b);
      logic signed [64:0] s;
      s = {a[63], a} - {b[63], b};
      if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
      return s[63:0];
    endfunction

    // (a*b) >> n rounded toward minus infinity, saturated
    function longint mul_floor(longint a, longint b, int n);
      logic signed [127:0] pa, pb, p;
      pa = a;
      pb = b;
      p = (pa * pb) >>> n;
      if (p[127:63] == '0 || p[127:63] == '1) return p[63:0];
      return p[127] ? S64_MIN : S64_MAX;
    endfunction

    // (num << sh) / den truncated toward zero, saturated; zero for den <= 0
    function longint div_trunc(longint num, int sh, longint den);
      logic [127:0] n, q;
      logic [63:0]  m;
      if (den <= 0) return 0;
      m = (num < 0) ? -num : num;
      n = {64'd0, m} << sh;
      q = n / {64'd0, den};
      if (q[127:63] != '0) return (num < 0) ? S64_MIN : S64_MAX;
      return (num < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    // square of a Q16.16 sigma, scaled to frac bits, saturated
    function longint sigma_sq(logic [31:0] s, int frac);
      logic [63:0] v;
      int          sh;
      v = {32'd0, s} * {32'd0, s};
      sh = frac - 32;
      if (v > (64'h7FFF_FFFF_FFFF_FFFF >> sh)) return S64_MAX;
      return v << sh;
    endfunction

    function void prime(longint dev, longint loc);
      off_est = sub_sat(loc, dev);
      skew_est = 0;
      p_oo = sigma_sq(regs[CFG_START_OFF], 32);
      p_os = 0;
      p_ss = sigma_sq(regs[CFG_START_SKEW], 56);
      last_upd = dev;
      primed = 1;
    endfunction

    function st_t kalman_update(longint dev, longint loc);
      longint dt, xp, res, t, p00, p01, p11, s, k0, k1;
      dt = sub_sat(dev, last_upd);
      if (dt < longint'({16'd0, regs[CFG_INTERVAL], 16'd0})) return ST_SOON;
      xp = add_sat(off_est, mul_floor(dt, skew_est, 62));
      res = sub_sat(sub_sat(loc, dev), xp);
      if (res > longint'({15'd0, regs[CFG_SIG_MEAS], 17'd0})) return ST_OUTLIER;
      t = mul_floor(dt, p_os, 48);
      p00 = add_sat(add_sat(add_sat(p_oo, t), t),
                    mul_floor(mul_floor(dt, dt, 32), p_ss, 56));
      p00 = add_sat(p00, mul_floor(dt, sigma_sq(regs[CFG_DRIFT_OFF], 32), 32));
      p01 = add_sat(p_os, mul_floor(dt, p_ss, 40));
      p11 = add_sat(p_ss, mul_floor(dt, sigma_sq(regs[CFG_DRIFT_SKEW], 56), 32));
      s = add_sat(p00, sigma_sq(regs[CFG_SIG_MEAS], 32));
      k0 = div_trunc(p00, 62, s);
      k1 = div_trunc(p01, 32, s);
      off_est = add_sat(xp, mul_floor(k0, res, 62));
      skew_est = add_sat(skew_est, mul_floor(k1, res, 18));
      p_oo = sub_sat(p00, mul_floor(k0, p00, 62));
      p_os = sub_sat(p01, mul_floor(k0, p01, 62));
      p_ss = sub_sat(p11, mul_floor(k1, p01, 40));
      last_upd = dev;
      return ST_UPDATED;
    endfunction

    // advance the predictor by one accepted input word
    function void note_input(in_word_t w);
      out_word_t e;
      longint    dev, loc;
      dev = w.device_time;
      loc = w.local_time;
      e.mapped_time = 0;
      if (w.op != OP_UPDATE && w.op != OP_QUERY) begin
        primed = 0;
        e.status = ST_CLEARED;
      end else if (!primed) begin
        prime(dev, loc);
        e.status = (w.op == OP_UPDATE) ? ST_INIT : ST_STAMP;
      end else begin
        e.status = (w.op == OP_UPDATE) ? kalman_update(dev, loc) : ST_STAMP;
      end
      if (w.op == OP_QUERY)
        e.mapped_time = add_sat(add_sat(dev, off_est),
                                mul_floor(sub_sat(dev, last_upd), skew_est, 62));
      e.offset_estimate = off_est;
      e.skew_estimate = skew_est;
      status_seen[e.status]++;
      expected_words.push_back(e);
    endfunction

    function void note_mismatch(string what, out_word_t e, out_word_t r);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %0s: exp st=%0d map=%h off=%h skew=%h | got st=%0d map=%h off=%h skew=%h",
                 what, e.status, e.mapped_time, e.offset_estimate, e.skew_estimate,
                 r.status, r.mapped_time, r.offset_estimate, r.skew_estimate);
    endfunction

    // compare one accepted result word with the oldest expectation
    function void check_result(out_word_t r);
      out_word_t e;
      if (expected_words.size() == 0) begin
        e = '0;
        note_mismatch("unexpected word", e, r);
        return;
      end
      e = expected_words.pop_front();
      checked++;
      if (r.status !== e.status) note_mismatch("status", e, r);
      else if (r.mapped_time !== e.mapped_time) note_mismatch("mapped_time", e, r);
      else if (r.offset_estimate !== e.offset_estimate) note_mismatch("offset", e, r);
      else if (r.skew_estimate !== e.skew_estimate) note_mismatch("skew", e, r);
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and clocking
  // --------------------------------------------------------------------------
  logic        clk = 0;
  logic        rst = 1;
  logic        item_valid = 0;
  logic        item_stall;
  in_word_t    item = '0;
  logic        result_valid;
  logic        result_stall = 0;
  out_word_t   result;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  clock_offset_skew_kalman dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .item(item),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  kalman_scoreboard sb = new();

  // receiver long hold-off request, counted down by the receiver process
  int hold_left = 0;

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) sb.note_input(item);
      if (result_valid && !result_stall) sb.check_result(result);
    end
  end

  // receiver: stall on a pattern picked at random from four
  initial begin : receiver
    int cyc;
    int mode;
    cyc = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 256 == 0) mode = $urandom_range(0, 3);
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1;
      end else begin
        case (mode)
          0: result_stall <= 0;
          1: result_stall <= ($urandom_range(0, 3) == 0);
          2: result_stall <= (cyc % 8 < 3);
          default: result_stall <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender and register tasks
  // --------------------------------------------------------------------------
  int burst_left = 0;

  // offer one word and hold it until taken; returns at a falling edge
  task automatic send_word(logic [1:0] op, longint dev, longint loc);
    in_word_t w;
    int       gap;
    w.op = op;
    w.device_time = dev;
    w.local_time = loc;
    item_valid <= 1;
    item <= w;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
    // bursts of random length with random gaps between them
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 7);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        item_valid <= 0;
        repeat (gap - 1) @(negedge clk);
        if (gap > 1) @(negedge clk);
      end
    end
  endtask

  // drop valid and wait for every expected word, then idle before returning
  task automatic drain();
    @(negedge clk);
    item_valid <= 0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 0;
    @(negedge clk);
  endtask

  task automatic write_all(logic [31:0] iv, logic [31:0] sm, logic [31:0] so,
                           logic [31:0] ss, logic [31:0] dof, logic [31:0] dsk);
    write_reg(CFG_INTERVAL, iv);
    write_reg(CFG_SIG_MEAS, sm);
    write_reg(CFG_START_OFF, so);
    write_reg(CFG_START_SKEW, ss);
    write_reg(CFG_DRIFT_OFF, dof);
    write_reg(CFG_DRIFT_SKEW, dsk);
  endtask

  function automatic longint rand64();
    return {$urandom, $urandom};
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  longint dev_now, true_off, true_skew_step;

  // one item of a plausible trajectory: mostly good updates, some too soon,
  // some outliers, queries, clears and raw noise
  task automatic trajectory_item();
    int     pick;
    longint iv, sig, gap, noise, loc;
    pick = $urandom_range(0, 99);
    iv = longint'({16'd0, sb.regs[CFG_INTERVAL], 16'd0});
    sig = longint'({16'd0, sb.regs[CFG_SIG_MEAS], 16'd0});
    if (pick < 60) begin
      gap = iv + longint'($urandom_range(1, 32'hFFFF_FFFF));
      dev_now += gap;
      true_off += true_skew_step;
      noise = (sig > 0) ? (longint'($urandom) % sig) : 0;
      loc = dev_now + true_off + noise;
      send_word(OP_UPDATE, dev_now, loc);
    end else if (pick < 68) begin
      // too soon, occasionally behind the last update
      send_word(OP_UPDATE, dev_now - longint'($urandom_range(0, 65536)),
                dev_now + true_off);
    end else if (pick < 75) begin
      dev_now += iv + ONE_SEC;
      send_word(OP_UPDATE, dev_now, dev_now + true_off + 3 * sig + ONE_SEC);
    end else if (pick < 88) begin
      send_word(OP_QUERY, dev_now + longint'($urandom), rand64());
    end else if (pick < 92) begin
      send_word(($urandom_range(0, 1) != 0) ? OP_CLEAR : OP_SPARE, rand64(), rand64());
    end else begin
      send_word(2'($urandom_range(0, 3)), rand64(), rand64());
    end
  endtask

  initial begin : stimulus
    int ph, i, total;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    write_all(32'h0000_8000, 32'h0000_0200, 32'h0001_0000,
              32'h0000_0100, 32'h0000_0010, 32'h0000_0004);

    // directed: first pair, too soon, negative gap, good update, outlier,
    // queries, time extremes, clears, query before init, opcode three
    send_word(OP_UPDATE, ONE_SEC * 100, ONE_SEC * 105);
    send_word(OP_UPDATE, ONE_SEC * 100, ONE_SEC * 105);
    send_word(OP_UPDATE, ONE_SEC * 99, ONE_SEC * 104);
    send_word(OP_UPDATE, ONE_SEC * 101, ONE_SEC * 106 + 64'd1000);
    send_word(OP_UPDATE, ONE_SEC * 103, ONE_SEC * 200);
    send_word(OP_UPDATE, ONE_SEC * 104, ONE_SEC * 10);
    send_word(OP_QUERY, ONE_SEC * 110, 0);
    send_word(OP_QUERY, S64_MAX, S64_MIN);
    send_word(OP_QUERY, S64_MIN, S64_MAX);
    send_word(OP_UPDATE, S64_MAX, S64_MIN);
    send_word(OP_UPDATE, S64_MAX, S64_MAX);
    send_word(OP_CLEAR, 0, 0);
    send_word(OP_QUERY, ONE_SEC * 5, ONE_SEC * 7);
    send_word(OP_SPARE, -1, -1);
    send_word(OP_UPDATE, S64_MIN, S64_MAX);
    send_word(OP_UPDATE, 0, 0);
    send_word(OP_QUERY, -1, -1);
    send_word(OP_CLEAR, S64_MAX, S64_MIN);
    send_word(OP_UPDATE, -1, 0);
    send_word(OP_UPDATE, ONE_SEC, -ONE_SEC);
    drain();

    total = 0;
    for (ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: ;
        1: write_all('0, '0, '0, '0, '0, '0);
        2: write_all('1, '1, '1, '1, '1, '1);
        3: write_all($urandom_range(0, 32'h0002_0000), $urandom_range(0, 32'h0000_1000),
                     $urandom, $urandom_range(0, 32'h0001_0000),
                     $urandom_range(0, 32'h0000_1000), $urandom);
        default: write_all(32'h0000_0000, 32'h0000_0040, 32'h0000_4000,
                           32'h0000_0400, 32'h0000_0001, 32'h0000_0001);
      endcase
      dev_now = longint'($urandom) << 8;
      true_off = rand64() >>> 24;
      true_skew_step = longint'($urandom_range(0, 4096)) - 2048;
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        // hold the receiver off for a long stretch while words keep coming
        if (ph == 2 && i == 40) hold_left = 3000;
        trajectory_item();
        total++;
      end
      drain();
    end

    while (sb.pending() > 0) @(posedge clk);
    repeat (30) @(posedge clk);

    $display("%0d words checked over %0d phases: init %0d, updated %0d, too soon %0d,",
             sb.checked, N_PHASES, sb.status_seen[ST_INIT], sb.status_seen[ST_UPDATED],
             sb.status_seen[ST_SOON]);
    $display("outlier %0d, timestamp %0d, cleared %0d; %0d mismatches",
             sb.status_seen[ST_OUTLIER], sb.status_seen[ST_STAMP],
             sb.status_seen[ST_CLEARED], sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog: generous bound on the slowest correct run
  initial begin : watchdog
    #100000000;
    $display("timeout with %0d words outstanding", sb.pending());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
